FILE: hdl/crmc_pkg.sv
// ----------------------------------------------------------------------------
// crmc_pkg
// Shared codes for the cache replacement miss classifier.
// ----------------------------------------------------------------------------
package crmc_pkg;

    // Replacement policy codes (any other code behaves as FIFO)
    localparam logic [1:0] POLICY_FIFO  = 2'd0;
    localparam logic [1:0] POLICY_LRU   = 2'd1;
    localparam logic [1:0] POLICY_CLOCK = 2'd2;

    // Miss classification codes
    localparam logic [1:0] KIND_HIT        = 2'd0;
    localparam logic [1:0] KIND_COMPULSORY = 2'd1;
    localparam logic [1:0] KIND_CAPACITY   = 2'd2;

    // Configuration register indexes
    localparam logic CFG_POLICY_MODE = 1'b0;
    localparam logic CFG_WAYS_IN_USE = 1'b1;

    localparam int CFG_DATA_BITS = 5;
    localparam int KEY_PORT_BITS = 16;
    localparam int OUT_DATA_BITS = 72;

endpackage

FILE: hdl/cache_replacement_miss_classifier.sv
// A hit or a fill passes the look-up, decide and output steps; a FIFO/LRU eviction
// adds a replace step, and a Clock eviction adds a sweep that clears each set reference bit
// it passes (at most ways_in_use) before the replace step.
// A new request is taken only in the idle state, once the output step has loaded the last
// result; the output step waits while an untaken result still holds the result register.
// Reset: asynchronous, active low; a clearing pass then zeroes all 2**KEY_BITS bits of the seen bitmap.
// ----------------------------------------------------------------------------
// cache_replacement_miss_classifier
// Fully associative cache directory with FIFO, LRU or Clock replacement that
// classifies each request as hit, compulsory miss or capacity miss.
// ----------------------------------------------------------------------------
module cache_replacement_miss_classifier #(
    parameter int WAYS     = 16,
    parameter int KEY_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic                                   cfg_index,
    input  logic [crmc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // request stream; tdata: request_key[15:0]
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [crmc_pkg::KEY_PORT_BITS-1:0]     s_axis_tdata,
    // result stream; tdata: hit[0], miss_kind[2:1], compulsory_count[34:3],
    // capacity_count[66:35], zero fill [71:67]
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [crmc_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata
);
    import crmc_pkg::*;

    localparam int HW  = (WAYS > 1) ? $clog2(WAYS) : 1;   // entry index width
    localparam int OW  = $clog2(WAYS + 1);                // occupancy width
    localparam int SW  = (OW > CFG_DATA_BITS) ? OW : CFG_DATA_BITS;
    localparam int KW  = KEY_BITS;
    localparam int SEEN_DEPTH = 1 << KW;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_LOOK   = 7'b0000100,
        ST_DECIDE = 7'b0001000,
        ST_SWEEP  = 7'b0010000,
        ST_REPL   = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg;

    // configuration
    logic [1:0]               policy_reg;
    logic [CFG_DATA_BITS-1:0] ways_reg;

    // directory state
    logic [KW-1:0] keys_reg [WAYS];
    logic [HW-1:0] age_reg  [WAYS];
    logic [WAYS-1:0] ref_reg;
    logic [OW-1:0] occ_reg;
    logic [HW-1:0] ptr_reg;
    logic [31:0]   comp_reg;
    logic [31:0]   cap_reg;

    // per-request working registers
    logic [KW-1:0] key_reg;
    logic          hit_reg;
    logic [HW-1:0] hit_idx_reg;
    logic [HW-1:0] age0_idx_reg;
    logic [HW-1:0] hand_reg;
    logic [OW-1:0] steps_reg;
    logic [HW-1:0] victim_reg;
    logic [1:0]    kind_reg;
    logic [KW-1:0] clr_reg;

    // seen bitmap memory
    logic          seen_mem [SEEN_DEPTH];
    logic          seen_rd_reg;
    logic          seen_we;
    logic [KW-1:0] seen_waddr;
    logic          seen_wdata;

    // result register
    logic          out_valid_reg;
    logic          out_hit_reg;
    logic [1:0]    out_kind_reg;
    logic [31:0]   out_comp_reg;
    logic [31:0]   out_cap_reg;

    // effective size, clamped to 1..WAYS
    logic [SW-1:0] ways_ext;
    logic [OW-1:0] size;
    logic          found;
    logic [HW-1:0] found_idx;
    logic [HW-1:0] age0_idx;
    logic [HW-1:0] hand_start;
    logic [HW-1:0] fill_slot;

    function automatic logic [HW-1:0] next_hand(input logic [HW-1:0] h,
                                                input logic [OW-1:0] sz);
        logic [OW:0] hx;
        begin
            hx = (OW+1)'(h);
            if (hx >= (OW+1)'(sz) - (OW+1)'(1))
                next_hand = '0;
            else
                next_hand = h + HW'(1);
        end
    endfunction

    assign ways_ext = SW'(ways_reg);
    always_comb
    begin
        if (ways_ext == '0)
            size = OW'(1);
        else if (ways_ext > SW'(WAYS))
            size = OW'(WAYS);
        else
            size = OW'(ways_ext);
    end

    // Parallel tag compare and oldest-entry search over filled entries;
    // scan downwards so the lowest matching entry wins.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        age0_idx  = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (OW'(i) < occ_reg && keys_reg[i] == key_reg)
            begin
                found     = 1'b1;
                found_idx = HW'(i);
            end
            if (OW'(i) < occ_reg && age_reg[i] == '0)
                age0_idx = HW'(i);
        end
    end

    // A hand left beyond a shrunk size restarts at entry 0
    assign hand_start = ((OW+1)'(ptr_reg) >= (OW+1)'(size)) ? '0 : ptr_reg;
    assign fill_slot  = HW'(occ_reg);

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_cap_reg, out_comp_reg, out_kind_reg, out_hit_reg};

    // seen bitmap write port: zero during the clearing pass, mark the victim
    // key during replacement
    always_comb
    begin
        seen_we    = 1'b0;
        seen_waddr = clr_reg;
        seen_wdata = 1'b0;
        if (state_reg == ST_CLEAR)
        begin
            seen_we = 1'b1;
        end
        else if (state_reg == ST_REPL)
        begin
            seen_we    = 1'b1;
            seen_waddr = keys_reg[victim_reg];
            seen_wdata = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
            seen_mem[seen_waddr] <= seen_wdata;
        if (state_reg == ST_LOOK)
            seen_rd_reg <= seen_mem[key_reg];
    end

    // directory payload, no reset needed for the stored keys
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DECIDE && !hit_reg && occ_reg < size)
            keys_reg[fill_slot] <= key_reg;
        else if (state_reg == ST_REPL)
            keys_reg[victim_reg] <= key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            policy_reg    <= POLICY_FIFO;
            ways_reg      <= CFG_DATA_BITS'(16);
            occ_reg       <= '0;
            ref_reg       <= '0;
            ptr_reg       <= '0;
            comp_reg      <= '0;
            cap_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WAYS; i++)
                age_reg[i] <= '0;
        end
        else
        begin
            // configuration transfer
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_POLICY_MODE: policy_reg <= cfg_data[1:0];
                    CFG_WAYS_IN_USE: ways_reg   <= cfg_data;
                    default:         ways_reg   <= ways_reg;
                endcase
            end

            // drop the result once taken, unless a new one replaces it
            if (out_valid_reg && m_axis_tready && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + KW'(1);
                    if (clr_reg == {KW{1'b1}})
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        key_reg   <= KW'(s_axis_tdata);
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    hit_reg      <= found;
                    hit_idx_reg  <= found_idx;
                    age0_idx_reg <= age0_idx;
                    state_reg    <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    if (hit_reg)
                    begin
                        kind_reg  <= KIND_HIT;
                        state_reg <= ST_OUT;
                        if (policy_reg == POLICY_LRU)
                        begin
                            for (int i = 0; i < WAYS; i++)
                                if (OW'(i) < occ_reg && age_reg[i] > age_reg[hit_idx_reg])
                                    age_reg[i] <= age_reg[i] - HW'(1);
                            age_reg[hit_idx_reg] <= HW'(occ_reg - OW'(1));
                        end
                        else if (policy_reg == POLICY_CLOCK)
                            ref_reg[hit_idx_reg] <= 1'b1;
                    end
                    else if (occ_reg < size)
                    begin
                        // fill the next free entry
                        ref_reg[fill_slot] <= 1'b0;
                        age_reg[fill_slot] <= HW'(occ_reg);
                        occ_reg            <= occ_reg + OW'(1);
                        comp_reg           <= (comp_reg == '1) ? comp_reg : comp_reg + 32'd1;
                        kind_reg           <= KIND_COMPULSORY;
                        state_reg          <= ST_OUT;
                    end
                    else if (policy_reg == POLICY_CLOCK)
                    begin
                        hand_reg  <= hand_start;
                        steps_reg <= '0;
                        state_reg <= ST_SWEEP;
                    end
                    else
                    begin
                        victim_reg <= age0_idx_reg;
                        state_reg  <= ST_REPL;
                    end
                end
                ST_SWEEP:
                begin
                    // clear one set reference bit a cycle and advance the hand
                    if (steps_reg < size && ref_reg[hand_reg])
                    begin
                        ref_reg[hand_reg] <= 1'b0;
                        hand_reg          <= next_hand(hand_reg, size);
                        steps_reg         <= steps_reg + OW'(1);
                    end
                    else
                    begin
                        victim_reg <= hand_reg;
                        state_reg  <= ST_REPL;
                    end
                end
                ST_REPL:
                begin
                    if (seen_rd_reg)
                    begin
                        cap_reg  <= (cap_reg == '1) ? cap_reg : cap_reg + 32'd1;
                        kind_reg <= KIND_CAPACITY;
                    end
                    else
                    begin
                        comp_reg <= (comp_reg == '1) ? comp_reg : comp_reg + 32'd1;
                        kind_reg <= KIND_COMPULSORY;
                    end
                    ref_reg[victim_reg] <= 1'b0;
                    for (int i = 0; i < WAYS; i++)
                        if (OW'(i) < occ_reg && age_reg[i] > age_reg[victim_reg])
                            age_reg[i] <= age_reg[i] - HW'(1);
                    age_reg[victim_reg] <= HW'(occ_reg - OW'(1));
                    if (policy_reg == POLICY_CLOCK)
                        ptr_reg <= next_hand(victim_reg, size);
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    // hold until the result register is free
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_hit_reg   <= hit_reg;
                        out_kind_reg  <= kind_reg;
                        out_comp_reg  <= comp_reg;
                        out_cap_reg   <= cap_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
